FILE: design/r2i_pkg.sv
// ============================================================================
// r2i_pkg: shared constants and helpers for the RGBA to I420 flip converter
// Fixed-point coefficients (Q16), field widths and the clamp-and-floor helper.
// ============================================================================
package r2i_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int CHAN_W         = 8;
    localparam int POS_W          = 12;
    localparam int DIM_W          = 13;
    localparam int CFG_IDX_W      = 2;
    localparam int SUM_W          = 27;

    localparam logic [DIM_W-1:0] MAX_DIM = 13'd4096;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // reset values of the dimension registers
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd960;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd540;

    // Q16 coefficient magnitudes
    localparam logic signed [SUM_W-1:0] C_Y_R  = 27'sd13933;
    localparam logic signed [SUM_W-1:0] C_Y_G  = 27'sd46871;
    localparam logic signed [SUM_W-1:0] C_Y_B  = 27'sd4732;
    localparam logic signed [SUM_W-1:0] C_U_R  = 27'sd7510;
    localparam logic signed [SUM_W-1:0] C_U_G  = 27'sd25258;
    localparam logic signed [SUM_W-1:0] C_UV_H = 27'sd32768;
    localparam logic signed [SUM_W-1:0] C_V_G  = 27'sd29767;
    localparam logic signed [SUM_W-1:0] C_V_B  = 27'sd3001;

    // offsets 16 and 128 in the sum's fixed-point format
    localparam logic signed [SUM_W-1:0] OFS_Y  = 27'sd16 <<< COEF_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] OFS_UV = 27'sd128 <<< COEF_FRAC_BITS;

    // one pixel waiting in the input stage, already placed in the frame
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic              chroma_en;
        logic              last;
    } pix_t;

    // negative gives 0; otherwise floor, then saturate at 255
    function automatic logic [CHAN_W-1:0] sat_floor(input logic signed [SUM_W-1:0] s);
        logic [CHAN_W-1:0] q;
        q = s[COEF_FRAC_BITS+CHAN_W-1:COEF_FRAC_BITS];
        if (s[SUM_W-1])
            return '0;
        else if (|s[SUM_W-2:COEF_FRAC_BITS+CHAN_W])
            return '1;
        else
            return q;
    endfunction

endpackage

FILE: design/rgba_to_i420_flip_converter.sv
// ============================================================================
// rgba_to_i420_flip_converter: RGB pixel stream to Y/U/V with vertical flip
// Places each pixel by column and source row, flips the row, and produces
// BT.709 luma per pixel and point-sampled 4:2:0 chroma (full-range weights).
// ============================================================================
//
// Usage:
//   Input channel  (in_valid / in_stall): one request carries one source
//   pixel (red, green, blue) in memory order, source rows bottom-up.
//   Output channel (out_valid / out_stall): one request per pixel with luma,
//   chroma_valid, chroma_u, chroma_v, out_col, out_row and frame_last.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0
//   is frame_width, index 1 is frame_height; cfg_ready is always high.
//   Any write to a known register restarts the frame at pixel 0; writes to
//   other indexes are dropped. Write only while the block is idle.
// Stages and rate:
//   Two register stages: an input stage that holds the placed pixel and a
//   result stage that holds the converted sample. An accepted pixel moves
//   from the input stage into the result stage and on to the output; one
//   pixel is taken per cycle unless a full pipeline is held by out_stall;
//   the constant-coefficient multiply-add between the stages sets the clock period.
// Reset and stall:
//   Reset empties both stages, clears the counters and loads 960 x 540.
//   While out_stall is high a full result stage holds; the input stage still
//   fills, so in_stall rises only once both stages are full.
//
module rgba_to_i420_flip_converter
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [r2i_pkg::CHAN_W-1:0]         red,
    input  logic [r2i_pkg::CHAN_W-1:0]         green,
    input  logic [r2i_pkg::CHAN_W-1:0]         blue,

    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [r2i_pkg::CHAN_W-1:0]         luma,
    output logic                               chroma_valid,
    output logic [r2i_pkg::CHAN_W-1:0]         chroma_u,
    output logic [r2i_pkg::CHAN_W-1:0]         chroma_v,
    output logic [r2i_pkg::POS_W-1:0]          out_col,
    output logic [r2i_pkg::POS_W-1:0]          out_row,
    output logic                               frame_last,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [r2i_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [r2i_pkg::DIM_W-1:0]          cfg_data
);

    // ------------------------------------------------------------------
    // configuration registers and pixel counters
    // ------------------------------------------------------------------
    logic [r2i_pkg::DIM_W-1:0] frame_width_reg;
    logic [r2i_pkg::DIM_W-1:0] frame_height_reg;
    logic [r2i_pkg::POS_W-1:0] col_reg;
    logic [r2i_pkg::POS_W-1:0] col_next;
    logic [r2i_pkg::POS_W-1:0] srow_reg;
    logic [r2i_pkg::POS_W-1:0] srow_next;

    logic [r2i_pkg::DIM_W-1:0] width_eff;
    logic [r2i_pkg::DIM_W-1:0] height_eff;
    logic [r2i_pkg::DIM_W-1:0] col_cur;
    logic [r2i_pkg::DIM_W-1:0] srow_cur;
    logic [r2i_pkg::DIM_W-1:0] col_inc;
    logic [r2i_pkg::DIM_W-1:0] srow_inc;
    logic [r2i_pkg::DIM_W-1:0] orow;
    logic                      last_col;
    logic                      last_row;
    logic                      cfg_hit;

    // ------------------------------------------------------------------
    // pipeline stages
    // ------------------------------------------------------------------
    r2i_pkg::pix_t             pix_reg;
    r2i_pkg::pix_t             pix_next;
    logic                      pix_valid_reg;
    logic                      res_load;
    logic                      pix_load;
    logic                      in_accept;

    logic signed [r2i_pkg::SUM_W-1:0] r_s;
    logic signed [r2i_pkg::SUM_W-1:0] g_s;
    logic signed [r2i_pkg::SUM_W-1:0] b_s;
    logic signed [r2i_pkg::SUM_W-1:0] y_sum;
    logic signed [r2i_pkg::SUM_W-1:0] u_sum;
    logic signed [r2i_pkg::SUM_W-1:0] v_sum;

    logic                          out_valid_reg;
    logic [r2i_pkg::CHAN_W-1:0]    luma_reg;
    logic [r2i_pkg::CHAN_W-1:0]    luma_next;
    logic                          chroma_valid_reg;
    logic [r2i_pkg::CHAN_W-1:0]    chroma_u_reg;
    logic [r2i_pkg::CHAN_W-1:0]    chroma_u_next;
    logic [r2i_pkg::CHAN_W-1:0]    chroma_v_reg;
    logic [r2i_pkg::CHAN_W-1:0]    chroma_v_next;
    logic [r2i_pkg::POS_W-1:0]     out_col_reg;
    logic [r2i_pkg::POS_W-1:0]     out_row_reg;
    logic                          frame_last_reg;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       (cfg_index == r2i_pkg::REG_FRAME_WIDTH ||
                        cfg_index == r2i_pkg::REG_FRAME_HEIGHT);

    // Treat a zero dimension as 1 and saturate large ones at the maximum.
    always_comb
    begin
        if (frame_width_reg == '0)
            width_eff = r2i_pkg::DIM_W'(1);
        else if (frame_width_reg > r2i_pkg::MAX_DIM)
            width_eff = r2i_pkg::MAX_DIM;
        else
            width_eff = frame_width_reg;

        if (frame_height_reg == '0)
            height_eff = r2i_pkg::DIM_W'(1);
        else if (frame_height_reg > r2i_pkg::MAX_DIM)
            height_eff = r2i_pkg::MAX_DIM;
        else
            height_eff = frame_height_reg;
    end

    // Place the pixel at the head of the input channel.
    always_comb
    begin
        col_cur  = {1'b0, col_reg};
        srow_cur = {1'b0, srow_reg};
        if (col_cur >= width_eff)
            col_cur = width_eff - r2i_pkg::DIM_W'(1);
        if (srow_cur >= height_eff)
            srow_cur = height_eff - r2i_pkg::DIM_W'(1);
        col_inc  = col_cur + r2i_pkg::DIM_W'(1);
        srow_inc = srow_cur + r2i_pkg::DIM_W'(1);
        orow     = height_eff - r2i_pkg::DIM_W'(1) - srow_cur;
        last_col = col_inc >= width_eff;
        last_row = srow_inc >= height_eff;
    end

    // Advance on every accepted pixel and wrap at row/frame end; cfg_hit clears.
    always_comb
    begin
        col_next  = col_reg;
        srow_next = srow_reg;
        if (cfg_hit)
        begin
            col_next  = '0;
            srow_next = '0;
        end
        else if (in_accept)
        begin
            if (last_col)
            begin
                col_next  = '0;
                srow_next = last_row ? '0 : srow_inc[r2i_pkg::POS_W-1:0];
            end
            else
            begin
                col_next  = col_inc[r2i_pkg::POS_W-1:0];
                srow_next = srow_cur[r2i_pkg::POS_W-1:0];
            end
        end
    end

    // Stage handshake: the result stage loads when empty or draining, the
    // input stage loads when empty or moving into the result stage.
    assign res_load  = !out_valid_reg || !out_stall;
    assign pix_load  = !pix_valid_reg || res_load;
    assign in_stall  = !pix_load;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        pix_next.red       = red;
        pix_next.green     = green;
        pix_next.blue      = blue;
        pix_next.col       = col_cur[r2i_pkg::POS_W-1:0];
        pix_next.row       = orow[r2i_pkg::POS_W-1:0];
        pix_next.chroma_en = !col_cur[0] && !orow[0];
        pix_next.last      = last_col && last_row;
    end

    // ------------------------------------------------------------------
    // color conversion: Q16 multiply-add, then clamp and floor
    // ------------------------------------------------------------------
    assign r_s = $signed({{(r2i_pkg::SUM_W-r2i_pkg::CHAN_W){1'b0}}, pix_reg.red});
    assign g_s = $signed({{(r2i_pkg::SUM_W-r2i_pkg::CHAN_W){1'b0}}, pix_reg.green});
    assign b_s = $signed({{(r2i_pkg::SUM_W-r2i_pkg::CHAN_W){1'b0}}, pix_reg.blue});

    assign y_sum = r2i_pkg::OFS_Y + r2i_pkg::C_Y_R * r_s + r2i_pkg::C_Y_G * g_s
                 + r2i_pkg::C_Y_B * b_s;
    assign u_sum = r2i_pkg::OFS_UV - r2i_pkg::C_U_R * r_s - r2i_pkg::C_U_G * g_s
                 + r2i_pkg::C_UV_H * b_s;
    assign v_sum = r2i_pkg::OFS_UV + r2i_pkg::C_UV_H * r_s - r2i_pkg::C_V_G * g_s
                 - r2i_pkg::C_V_B * b_s;

    // Drop chroma on odd columns or odd output rows.
    assign luma_next     = r2i_pkg::sat_floor(y_sum);
    assign chroma_u_next = pix_reg.chroma_en ? r2i_pkg::sat_floor(u_sum) : '0;
    assign chroma_v_next = pix_reg.chroma_en ? r2i_pkg::sat_floor(v_sum) : '0;

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= r2i_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= r2i_pkg::FRAME_HEIGHT_RST;
            col_reg          <= '0;
            srow_reg         <= '0;
            pix_valid_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index == r2i_pkg::REG_FRAME_WIDTH)
                frame_width_reg <= cfg_data;
            if (cfg_valid && cfg_ready && cfg_index == r2i_pkg::REG_FRAME_HEIGHT)
                frame_height_reg <= cfg_data;
            col_reg  <= col_next;
            srow_reg <= srow_next;
            if (pix_load)
                pix_valid_reg <= in_valid;
            if (res_load)
                out_valid_reg <= pix_valid_reg;
        end
    end

    // payload: hold while the stage cannot advance
    always_ff @(posedge clk)
    begin
        if (in_accept)
            pix_reg <= pix_next;
        if (res_load && pix_valid_reg)
        begin
            luma_reg         <= luma_next;
            chroma_valid_reg <= pix_reg.chroma_en;
            chroma_u_reg     <= chroma_u_next;
            chroma_v_reg     <= chroma_v_next;
            out_col_reg      <= pix_reg.col;
            out_row_reg      <= pix_reg.row;
            frame_last_reg   <= pix_reg.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign luma         = luma_reg;
    assign chroma_valid = chroma_valid_reg;
    assign chroma_u     = chroma_u_reg;
    assign chroma_v     = chroma_v_reg;
    assign out_col      = out_col_reg;
    assign out_row      = out_row_reg;
    assign frame_last   = frame_last_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_chroma_even: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && chroma_valid |-> !out_col[0] && !out_row[0])
        else $error("chroma on an odd position");

    a_chroma_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chroma_valid |-> chroma_u == '0 && chroma_v == '0)
        else $error("chroma not cleared on a luma-only pixel");

    a_last_top_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> out_row == '0)
        else $error("frame end not on output row 0");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> pix_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled while a stage is free");

endmodule
